// ----- src/dtpm_pkg.sv -----
// Package for the dissolve transition pixel mixer: sizes, mask constants,
// the mode record passed to the pixel pipeline and the zigzag index function.
// No dependencies.
package dtpm_pkg;

  // Field widths
  localparam int PIXEL_BITS = 8;
  localparam int COORD_BITS = 10;
  localparam int STEP_BITS  = 8;
  localparam int WBLK_BITS  = 6;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 8;

  // Block geometry
  localparam int BLOCK_SIDE = 32;
  localparam int BLK_BITS   = 5;
  localparam int ZZ_BITS    = 2 * BLK_BITS;
  localparam int ZZ_W       = 2 * BLK_BITS + 1;
  localparam int BNUM_BITS  = 11;

  // Mask constants
  localparam int MASK_LEN = 79;
  localparam int MASK_INV = 34;
  localparam int MIDX_BITS = 7;
  localparam int BLK_RES = (BLOCK_SIDE * BLOCK_SIDE) % MASK_LEN;

  // Counter value t = blk*BLK_RES + z, then t mod 79 by reciprocal
  localparam int T_BITS      = 18;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_K     = ((1 << RECIP_SHIFT) + MASK_LEN - 1) / MASK_LEN;
  localparam int PROD_BITS   = 2 * T_BITS;
  localparam int QUO_BITS    = 11;

  // Threshold divider: strength*79 / half
  localparam int DVD_BITS  = 14;
  localparam int HALF_BITS = 7;
  localparam int DIV_STEPS = DVD_BITS;
  localparam int CNT_BITS  = 4;

  // (MASK_INV * m) mod MASK_LEN for m in 0..78
  localparam logic [MIDX_BITS-1:0] MASK_PERM [0:MASK_LEN-1] = '{
    7'd0,  7'd34, 7'd68, 7'd23, 7'd57, 7'd12, 7'd46,
    7'd1,  7'd35, 7'd69, 7'd24, 7'd58, 7'd13, 7'd47,
    7'd2,  7'd36, 7'd70, 7'd25, 7'd59, 7'd14, 7'd48,
    7'd3,  7'd37, 7'd71, 7'd26, 7'd60, 7'd15, 7'd49,
    7'd4,  7'd38, 7'd72, 7'd27, 7'd61, 7'd16, 7'd50,
    7'd5,  7'd39, 7'd73, 7'd28, 7'd62, 7'd17, 7'd51,
    7'd6,  7'd40, 7'd74, 7'd29, 7'd63, 7'd18, 7'd52,
    7'd7,  7'd41, 7'd75, 7'd30, 7'd64, 7'd19, 7'd53,
    7'd8,  7'd42, 7'd76, 7'd31, 7'd65, 7'd20, 7'd54,
    7'd9,  7'd43, 7'd77, 7'd32, 7'd66, 7'd21, 7'd55,
    7'd10, 7'd44, 7'd78, 7'd33, 7'd67, 7'd22, 7'd56,
    7'd11, 7'd45
  };

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PROGRESS = 2'd0,
    CFG_TOTAL    = 2'd1,
    CFG_WIDTH    = 2'd2
  } cfg_idx_e;

  // Divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_e;

  // Per-frame mix decision handed to the pixel pipeline
  typedef struct packed {
    logic                 use_new;    // base is the new pixel
    logic                 all_black;  // every pixel black
    logic                 mask_en;    // mask decides per pixel
    logic [MIDX_BITS-1:0] n_thresh;   // black when permuted slot < this
  } mode_t;

  // Position of (sx,sy) along the diagonal zigzag walk of one block
  function automatic logic [ZZ_BITS-1:0] zigzag_index(input logic [BLK_BITS-1:0] sx,
                                                      input logic [BLK_BITS-1:0] sy);
    logic [BLK_BITS:0] s;
    logic [BLK_BITS:0] j;
    logic [ZZ_W-1:0]   tsum;
    logic [ZZ_W-1:0]   start;
    logic [ZZ_W-1:0]   pos;
    s = {1'b0, sx} + {1'b0, sy};
    j = (BLK_BITS+1)'(2 * BLOCK_SIDE - 1) - s;
    if (s < (BLK_BITS+1)'(BLOCK_SIDE)) begin
      tsum  = (ZZ_W'(s) * (ZZ_W'(s) + ZZ_W'(1))) >> 1;
      start = tsum;
      pos   = s[0] ? ZZ_W'(sy) : ZZ_W'(sx);
    end else begin
      tsum  = (ZZ_W'(j) * (ZZ_W'(j) + ZZ_W'(1))) >> 1;
      start = ZZ_W'(BLOCK_SIDE * BLOCK_SIDE) - tsum;
      pos   = s[0] ? (ZZ_W'(BLOCK_SIDE - 1) - ZZ_W'(sx))
                   : (ZZ_W'(sx) - (ZZ_W'(s) - ZZ_W'(BLOCK_SIDE - 1)));
    end
    return ZZ_BITS'(start + pos);
  endfunction

endpackage

// ----- src/dtpm_stream_if.sv -----
// Valid/ready stream interfaces for pixel items going in and mixed items out.
// Depends on dtpm_pkg for field widths.
interface dtpm_in_if;
  logic                               valid;
  logic                               ready;
  logic [dtpm_pkg::COORD_BITS-1:0]    pix_x;
  logic [dtpm_pkg::COORD_BITS-1:0]    pix_y;
  logic [dtpm_pkg::PIXEL_BITS-1:0]    old_pixel;
  logic [dtpm_pkg::PIXEL_BITS-1:0]    new_pixel;

  modport source (output valid, pix_x, pix_y, old_pixel, new_pixel, input ready);
  modport sink   (input valid, pix_x, pix_y, old_pixel, new_pixel, output ready);
endinterface

interface dtpm_out_if;
  logic                               valid;
  logic                               ready;
  logic [dtpm_pkg::PIXEL_BITS-1:0]    pixel_out;
  logic                               blacked;

  modport source (output valid, pixel_out, blacked, input ready);
  modport sink   (input valid, pixel_out, blacked, output ready);
endinterface

// ----- src/dissolve_transition_pixel_mixer.sv -----
// Top level of the dissolve-through-black pixel mixer: configuration
// registers, divider and pixel pipeline. Depends on dtpm_pkg, dtpm_stream_if,
// dtpm_div and dtpm_pipe.
//
// Usage:
//   pix_in_i carries one item per pixel (x, y, old and new value); pix_out_o
//   returns one item per pixel (mixed value, blacked flag), in order.
//   Set progress, total_steps and width_blocks through cfg_we_i/cfg_idx_i/
//   cfg_data_i between frames, while no item is in flight.
// Pipeline: a result passes four register stages, the first loaded at the edge
//   that accepts its item.
// Throughput: one item per cycle when not stalled or held after a write.
// After a register write, pix_in_i.ready stays low through the write cycle, the
//   load state and the 14 steps of the serial threshold divider.
// Reset: progress=0, total_steps=0, width_blocks=1, pipeline empty.
// Stall: when pix_out_o.ready is low the output holds; earlier stages keep
//   filling their empty slots, and input is held off only once all are full.
module dissolve_transition_pixel_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  dtpm_in_if.sink                             pix_in_i,
  dtpm_out_if.source                          pix_out_o,
  input  logic                                cfg_we_i,
  input  logic [dtpm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [dtpm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import dtpm_pkg::*;

  logic [STEP_BITS-1:0]  progress_q;
  logic [STEP_BITS-1:0]  total_q;
  logic [WBLK_BITS-1:0]  width_q;
  mode_t                 mode;
  logic                  div_busy;
  logic                  hold;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      progress_q <= '0;
      total_q    <= '0;
      width_q    <= WBLK_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROGRESS: progress_q <= cfg_data_i[STEP_BITS-1:0];
        CFG_TOTAL:    total_q    <= cfg_data_i[STEP_BITS-1:0];
        CFG_WIDTH:    width_q    <= cfg_data_i[WBLK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // No new items while the threshold is being recomputed
  assign hold = div_busy || cfg_we_i;

  dtpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .progress_i (progress_q),
    .total_i    (total_q),
    .mode_o     (mode),
    .busy_o     (div_busy)
  );

  dtpm_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hold_i  (hold),
    .mode_i  (mode),
    .width_i (width_q),
    .pix_in  (pix_in_i),
    .pix_out (pix_out_o)
  );

endmodule

// ----- src/dtpm_div.sv -----
// Frame-level mix decision and bit-serial threshold divider (strength*79/half).
// Depends on dtpm_pkg.
module dtpm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [dtpm_pkg::STEP_BITS-1:0]     progress_i,
  input  logic [dtpm_pkg::STEP_BITS-1:0]     total_i,
  output dtpm_pkg::mode_t                    mode_o,
  output logic                               busy_o
);
  import dtpm_pkg::*;

  div_state_e              state_q, state_d;
  logic [CNT_BITS-1:0]     cnt_q;
  logic [DVD_BITS-1:0]     dvd_q;
  logic [HALF_BITS-1:0]    rem_q;
  logic [MIDX_BITS-1:0]    n_q;

  logic [STEP_BITS-1:0]    q_steps;
  logic [HALF_BITS-1:0]    half;
  logic                    q_lt_half;
  logic [STEP_BITS-1:0]    strength;
  logic [DVD_BITS-1:0]     dividend;
  logic [HALF_BITS:0]      rem_sh;
  logic                    qbit;
  logic [HALF_BITS-1:0]    rem_nx;
  logic [DVD_BITS-1:0]     quot_nx;

  // Mix decision from the step registers
  always_comb begin
    q_steps   = total_i - progress_i;
    half      = total_i[STEP_BITS-1:1];
    q_lt_half = q_steps < STEP_BITS'(half);
    strength  = q_lt_half ? q_steps : progress_i;
    dividend  = DVD_BITS'(strength) * DVD_BITS'(MASK_LEN);

    mode_o.use_new   = 1'b0;
    mode_o.all_black = 1'b0;
    mode_o.mask_en   = 1'b0;
    mode_o.n_thresh  = n_q;
    priority if (progress_i >= total_i) begin
      mode_o.use_new = 1'b0;
    end else if (progress_i == '0) begin
      mode_o.use_new = 1'b1;
    end else if (total_i < STEP_BITS'(2)) begin
      mode_o.use_new = 1'b0;
    end else if (strength >= STEP_BITS'(half)) begin
      mode_o.all_black = 1'b1;
    end else begin
      mode_o.use_new = !q_lt_half;
      mode_o.mask_en = 1'b1;
    end
  end

  // One restoring division step
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_BITS-1]};
    qbit    = rem_sh >= {1'b0, half};
    rem_nx  = qbit ? HALF_BITS'(rem_sh - {1'b0, half}) : rem_sh[HALF_BITS-1:0];
    quot_nx = {dvd_q[DVD_BITS-2:0], qbit};
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_LOAD;
      DIV_LOAD: state_d = start_i ? DIV_LOAD : DIV_RUN;
      DIV_RUN: begin
        if (start_i) state_d = DIV_LOAD;
        else if (cnt_q == '0) state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  assign busy_o = (state_q != DIV_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_LOAD) cnt_q <= CNT_BITS'(DIV_STEPS - 1);
      else if (state_q == DIV_RUN) cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  // Divider datapath: dividend register shifts the quotient in
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_LOAD) begin
      rem_q <= '0;
      dvd_q <= dividend;
    end else if (state_q == DIV_RUN) begin
      rem_q <= rem_nx;
      dvd_q <= quot_nx;
      if (cnt_q == '0) n_q <= quot_nx[MIDX_BITS-1:0];
    end
  end

endmodule

// ----- src/dtpm_pipe.sv -----
// Four-stage pixel pipeline: block/zigzag index, mask counter, mod 79 by
// reciprocal, mask lookup and output register. Depends on dtpm_pkg, dtpm_stream_if.
module dtpm_pipe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               hold_i,
  input  dtpm_pkg::mode_t                    mode_i,
  input  logic [dtpm_pkg::WBLK_BITS-1:0]     width_i,
  dtpm_in_if.sink                            pix_in,
  dtpm_out_if.source                         pix_out
);
  import dtpm_pkg::*;

  logic                   v1_q, v2_q, v3_q, v4_q;
  logic                   rdy1, rdy2, rdy3, rdy4;

  // Stage 1
  logic [PIXEL_BITS-1:0]  old1_q, new1_q;
  logic                   inb1_q;
  logic [BNUM_BITS-1:0]   blk1_q;
  logic [ZZ_BITS-1:0]     zz1_q;
  // Stage 2
  logic [PIXEL_BITS-1:0]  old2_q, new2_q;
  logic                   inb2_q;
  logic [T_BITS-1:0]      t2_q;
  // Stage 3
  logic [PIXEL_BITS-1:0]  old3_q, new3_q;
  logic                   inb3_q;
  logic [T_BITS-1:0]      t3_q;
  logic [PROD_BITS-1:0]   prod3_q;
  // Stage 4 (output)
  logic [PIXEL_BITS-1:0]  pix4_q;
  logic                   blk4_q;

  logic [BLK_BITS-1:0]    bx, by;
  logic [QUO_BITS-1:0]    quo;
  logic [T_BITS-1:0]      rem_full;
  logic [MIDX_BITS-1:0]   slot;
  logic                   hit;
  logic                   black;
  logic [PIXEL_BITS-1:0]  base;

  // Per-stage ready: a stage moves when its successor is empty or moving
  assign rdy4 = !v4_q || pix_out.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign pix_in.ready = rdy1 && !hold_i;

  assign bx = pix_in.pix_x[COORD_BITS-1 -: BLK_BITS];
  assign by = pix_in.pix_y[COORD_BITS-1 -: BLK_BITS];

  // Final stage: remainder, mask permutation, compare
  always_comb begin
    quo      = prod3_q[RECIP_SHIFT +: QUO_BITS];
    rem_full = t3_q - T_BITS'(quo) * T_BITS'(MASK_LEN);
    slot     = rem_full[MIDX_BITS-1:0];
    hit      = MASK_PERM[slot] < mode_i.n_thresh;
    black    = mode_i.all_black || (mode_i.mask_en && inb3_q && hit);
    base     = mode_i.use_new ? new3_q : old3_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_in.valid && pix_in.ready;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      old1_q <= pix_in.old_pixel;
      new1_q <= pix_in.new_pixel;
      inb1_q <= {1'b0, bx} < width_i;
      blk1_q <= BNUM_BITS'(by) * BNUM_BITS'(width_i) + BNUM_BITS'(bx);
      zz1_q  <= zigzag_index(pix_in.pix_x[BLK_BITS-1:0], pix_in.pix_y[BLK_BITS-1:0]);
    end
    if (rdy2) begin
      old2_q <= old1_q;
      new2_q <= new1_q;
      inb2_q <= inb1_q;
      t2_q   <= T_BITS'(blk1_q) * T_BITS'(BLK_RES) + T_BITS'(zz1_q);
    end
    if (rdy3) begin
      old3_q  <= old2_q;
      new3_q  <= new2_q;
      inb3_q  <= inb2_q;
      t3_q    <= t2_q;
      prod3_q <= PROD_BITS'(t2_q) * PROD_BITS'(RECIP_K);
    end
    if (rdy4) begin
      pix4_q <= black ? '0 : base;
      blk4_q <= black;
    end
  end

  assign pix_out.valid     = v4_q;
  assign pix_out.pixel_out = pix4_q;
  assign pix_out.blacked   = blk4_q;

endmodule

// ----- sim/tb_dissolve_transition_pixel_mixer.sv -----
// Self-checking testbench for the dissolve-through-black pixel mixer: drives pixel
// items and register writes, predicts every mixed pixel and compares it in order.
// Depends on dtpm_pkg, dtpm_stream_if and the dissolve_transition_pixel_mixer RTL.
module tb_dissolve_transition_pixel_mixer;
  import dtpm_pkg::*;

  localparam int MAX_SIDE         = 1024;
  localparam int FRAME_BLOCK_ROWS = MAX_SIDE / BLOCK_SIDE;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 8;
  // Index past the last register; writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  blacked;
  } mix_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  dtpm_in_if  pix_in ();
  dtpm_out_if pix_out ();

  dissolve_transition_pixel_mixer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in_i   (pix_in),
    .pix_out_o  (pix_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the block's registers, reset values
  logic [STEP_BITS-1:0] cfg_progress = '0;
  logic [STEP_BITS-1:0] cfg_total    = '0;
  logic [WBLK_BITS-1:0] cfg_width    = 6'd1;

  mix_result_t expected_mix_q[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 7;
  int          recv_idle_pct  = 83;
  int          stall_cycles   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mixed pixel for the current frame settings
  function automatic mix_result_t predict_mix(input logic [COORD_BITS-1:0] x,
                                              input logic [COORD_BITS-1:0] y,
                                              input logic [PIXEL_BITS-1:0] oldp,
                                              input logic [PIXEL_BITS-1:0] newp);
    mix_result_t r;
    int xi, yi, q, half, strength, thresh, blk, sx, sy, diag, j, walk, slot;
    logic [PIXEL_BITS-1:0] base;
    xi = int'(x);
    yi = int'(y);
    r.pixel_out = oldp;
    r.blacked   = 1'b0;
    if (cfg_progress >= cfg_total) begin
      r.pixel_out = oldp;
    end else if (cfg_progress == '0) begin
      r.pixel_out = newp;
    end else if (cfg_total < 2) begin
      r.pixel_out = oldp;
    end else begin
      q    = int'(cfg_total) - int'(cfg_progress);
      half = int'(cfg_total) >> 1;
      // first half fades the new frame out, second half fades the old one in
      if (q < half) begin
        base     = oldp;
        strength = q;
      end else begin
        base     = newp;
        strength = int'(cfg_total) - q;
      end
      r.pixel_out = base;
      if (strength >= half) begin
        r.pixel_out = '0;
        r.blacked   = 1'b1;
      end else if (xi / BLOCK_SIDE < int'(cfg_width) && yi / BLOCK_SIDE < FRAME_BLOCK_ROWS) begin
        thresh = strength * MASK_LEN / half;
        blk    = (yi / BLOCK_SIDE) * int'(cfg_width) + xi / BLOCK_SIDE;
        sx     = xi % BLOCK_SIDE;
        sy     = yi % BLOCK_SIDE;
        diag   = sx + sy;
        // position along the diagonal walk: upper-left triangle, then lower-right
        if (diag < BLOCK_SIDE) begin
          walk = diag * (diag + 1) / 2 + ((diag % 2 != 0) ? sy : sx);
        end else begin
          j    = 2 * BLOCK_SIDE - 1 - diag;
          walk = BLOCK_SIDE * BLOCK_SIDE - j * (j + 1) / 2
                 + ((diag % 2 != 0) ? (BLOCK_SIDE - 1 - sx) : (sx - (diag - BLOCK_SIDE + 1)));
        end
        slot = (blk * BLOCK_SIDE * BLOCK_SIDE + walk) % MASK_LEN;
        if ((MASK_INV * slot) % MASK_LEN < thresh) begin
          r.pixel_out = '0;
          r.blacked   = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Send one pixel item, with random idle cycles ahead of it
  task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [PIXEL_BITS-1:0] oldp,
                            input logic [PIXEL_BITS-1:0] newp);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid     <= 1'b1;
    pix_in.pix_x     <= x;
    pix_in.pix_y     <= y;
    pix_in.old_pixel <= oldp;
    pix_in.new_pixel <= newp;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    expected_mix_q.push_back(predict_mix(x, y, oldp, newp));
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    pix_in.valid <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk_i);
  endtask

  // One register write cycle; shadow copy follows the block's masking
  task automatic drive_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PROGRESS: cfg_progress = data;
      CFG_TOTAL:    cfg_total    = data;
      CFG_WIDTH:    cfg_width    = data[WBLK_BITS-1:0];
      default: ;
    endcase
  endtask

  // New frame settings, written only with the pipeline empty
  task automatic set_frame(input logic [STEP_BITS-1:0] prog, input logic [STEP_BITS-1:0] total,
                           input logic [CFG_DATA_BITS-1:0] wdata);
    drain_results();
    drive_reg(CFG_PROGRESS, prog);
    drive_reg(CFG_TOTAL, total);
    drive_reg(CFG_WIDTH, wdata);
    drive_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Reset values: progress equals total, so the old frame passes
  task automatic test_reset_state();
    send_pixel(10'd0, 10'd0, 8'h00, 8'hff);
    send_pixel(10'd1023, 10'd1023, 8'hff, 8'h00);
  endtask

  // Progress at or past total, and progress zero
  task automatic test_frame_endpoints();
    set_frame(8'd200, 8'd100, 8'd1);
    send_pixel(10'd5, 10'd7, 8'h5a, 8'ha5);
    send_pixel(10'd1023, 10'd0, 8'hff, 8'h01);
    set_frame(8'd0, 8'd255, 8'd32);
    send_pixel(10'd0, 10'd1023, 8'h80, 8'h7f);
    send_pixel(10'd300, 10'd300, 8'h00, 8'hff);
    set_frame(8'd255, 8'd255, 8'd32);
    send_pixel(10'd17, 10'd9, 8'hc3, 8'h3c);
  endtask

  // Strength reaches half: the whole frame goes black
  task automatic test_full_black();
    set_frame(8'd50, 8'd100, 8'd4);
    send_pixel(10'd0, 10'd0, 8'hff, 8'hff);
    send_pixel(10'd1023, 10'd1023, 8'h55, 8'haa);
  endtask

  // Mask inside blocks, pixels right of the last block, zero and masked widths
  task automatic test_mask_regions();
    set_frame(8'd10, 8'd255, 8'd2);
    send_pixel(10'd0, 10'd0, 8'h11, 8'h22);
    send_pixel(10'd31, 10'd31, 8'h33, 8'h44);
    send_pixel(10'd63, 10'd0, 8'h55, 8'h66);
    send_pixel(10'd64, 10'd5, 8'h77, 8'h88);
    send_pixel(10'd1023, 10'd1023, 8'h99, 8'haa);
    set_frame(8'd250, 8'd255, 8'hff);
    send_pixel(10'd1023, 10'd1023, 8'hbb, 8'hcc);
    send_pixel(10'd500, 10'd700, 8'hdd, 8'hee);
    set_frame(8'd120, 8'd255, 8'd0);
    send_pixel(10'd0, 10'd0, 8'h01, 8'hfe);
    send_pixel(10'd12, 10'd600, 8'h02, 8'hfd);
  endtask

  // Random frames, mostly in the middle of a transition with in-block pixels
  task automatic test_random_frames(input int frames, input int pixels_per_frame);
    int t, p, w, xmax;
    for (int f = 0; f < frames; f++) begin
      t = $urandom_range(255, 2);
      p = $urandom_range(t - 1, 1);
      case ($urandom_range(9))
        0: begin t = $urandom_range(255); p = $urandom_range(255); end
        1: p = 0;
        2: p = $urandom_range(255, t);
        default: ;
      endcase
      w = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(32, 1);
      set_frame(STEP_BITS'(p), STEP_BITS'(t), {2'($urandom), 6'(w)});
      xmax = (w * BLOCK_SIDE - 1 > MAX_SIDE - 1) ? MAX_SIDE - 1 : w * BLOCK_SIDE - 1;
      for (int i = 0; i < pixels_per_frame; i++) begin
        send_pixel((w > 0 && $urandom_range(3) != 0) ? COORD_BITS'($urandom_range(xmax))
                                                     : COORD_BITS'($urandom),
                   COORD_BITS'($urandom), PIXEL_BITS'($urandom), PIXEL_BITS'($urandom));
      end
    end
  endtask

  // Result side backpressure
  initial begin
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each returned item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    mix_result_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (expected_mix_q.size() == 0) begin
        $display("%0t: unexpected item: pixel_out=%0d blacked=%0d", $time,
                 pix_out.pixel_out, pix_out.blacked);
        mismatch_count++;
      end else begin
        want = expected_mix_q.pop_front();
        if (pix_out.pixel_out !== want.pixel_out) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel_out,
                   pix_out.pixel_out);
          mismatch_count++;
        end
        if (pix_out.blacked !== want.blacked) begin
          $display("%0t: blacked expected %0d actual %0d", $time, want.blacked,
                   pix_out.blacked);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    pix_in.valid     <= 1'b0;
    pix_in.pix_x     <= '0;
    pix_in.pix_y     <= '0;
    pix_in.old_pixel <= '0;
    pix_in.new_pixel <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_frame_endpoints();
    test_full_black();
    test_mask_regions();
    test_random_frames(8, 66);

    drain_results();
    send_idle_pct = 83;
    recv_idle_pct = 7;
    test_random_frames(8, 66);

    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(8, 66);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dtpm_pkg.sv
src/dtpm_stream_if.sv
src/dtpm_div.sv
src/dtpm_pipe.sv
src/dissolve_transition_pixel_mixer.sv
sim/tb_dissolve_transition_pixel_mixer.sv
